[hdl/pfba_pkg.sv]
// Shared types and constants for the page frame bitmap allocator.
`default_nettype none

package pfba_pkg;

   localparam int DEF_MAX_FRAMES = 4096;
   localparam int DEF_PAGE_BYTES = 4096;

   localparam int WORD_W     = 32;
   localparam int WORD_SH    = 5;
   localparam int ADDR_W     = 32;
   localparam int BASE_W     = 20;
   localparam int COUNT_W    = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_FRAME  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT = CSR_IDX_W'(1);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_FRAME = 2'd1,
      ST_RANGE    = 2'd2,
      ST_NOT_USED = 2'd3
   } status_type;

   typedef struct packed {
      logic       clear_wr;
      logic       latch_req;
      logic       scan_load;
      logic       scan_rd;
      logic       scan_inc;
      logic       free_rd;
      logic       alloc_commit;
      logic       free_commit;
      logic       res_load;
      status_type res_code;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_free;
      logic in_range;
      logic past_end;
      logic found;
      logic bit_used;
      logic slot_free;
   } stat_type;

endpackage

`default_nettype wire

[hdl/pfba_if.sv]
// Channel interfaces: request, response and register write.
`default_nettype none

interface pfba_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [pfba_pkg::ADDR_W-1:0] address;

   modport source (output valid, output opcode, output address, input ready);
   modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface pfba_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [pfba_pkg::ADDR_W-1:0] page_address;
   logic [1:0]                 status;

   modport source (output valid, output page_address, output status, input ready);
   modport sink   (input valid, input page_address, input status, output ready);
endinterface

interface pfba_csr_if;
   logic                           valid;
   logic                           ready;
   logic [pfba_pkg::CSR_IDX_W-1:0]  index;
   logic [pfba_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/pfba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pfba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

[hdl/pfba_datapath.sv]
// Allocator datapath: config registers, usage map, scan pointer, hint and result register.
`default_nettype none

module pfba_datapath #(
   parameter int MAX_FRAMES = pfba_pkg::DEF_MAX_FRAMES,
   parameter int PAGE_BYTES = pfba_pkg::DEF_PAGE_BYTES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire pfba_pkg::cmd_type               cmd,
   output pfba_pkg::stat_type                   stat,
   input  wire logic                            csr_we,
   input  wire logic [pfba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pfba_pkg::CSR_DATA_W-1:0] csr_data,
   input  wire logic                            req_opcode,
   input  wire logic [pfba_pkg::ADDR_W-1:0]     req_address,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic [pfba_pkg::ADDR_W-1:0]          rsp_page_address,
   output logic [1:0]                           rsp_status
);

   localparam int WORD_W = pfba_pkg::WORD_W;
   localparam int WSH    = pfba_pkg::WORD_SH;
   localparam int DEPTH  = (MAX_FRAMES + WORD_W - 1) / WORD_W;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HW     = $clog2(DEPTH + 1);
   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int PG_SH  = $clog2(PAGE_BYTES);

   logic [pfba_pkg::BASE_W-1:0]  base_ff;
   logic [pfba_pkg::COUNT_W-1:0] count_ff;
   logic                         opcode_ff;
   logic [pfba_pkg::ADDR_W-1:0]  address_ff;
   logic [HW-1:0]                ptr_ff, ptr_in;
   logic [HW-1:0]                hint_ff, hint_in;
   logic [pfba_pkg::ADDR_W-1:0]  page_addr_ff;
   pfba_pkg::status_type         status_ff;
   logic                         rsp_valid_ff;

   logic [CNT_W-1:0]  managed;
   logic [31:0]       n32, base32, word_base, rem, frame_f, rel, frame_a;
   logic [WORD_W-1:0] rdata, cand, set_word, clr_word;
   logic [WSH-1:0]    idx, fbit;
   logic [AW-1:0]     fword;
   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata;

   always_comb begin
      if (32'(count_ff) > 32'(MAX_FRAMES)) begin
         managed = CNT_W'(MAX_FRAMES);
      end else begin
         managed = CNT_W'(count_ff);
      end
   end

   assign n32       = 32'(managed);
   assign base32    = 32'(base_ff);
   assign word_base = 32'(ptr_ff) << WSH;
   assign rem       = n32 - word_base;

   always_comb begin
      idx = '0;
      for (int b = 0; b < WORD_W; b++) begin
         cand[b] = !rdata[b] && (32'(b) < rem);
      end
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (cand[b]) begin
            idx = WSH'(b);
         end
      end
   end

   assign set_word = rdata | (WORD_W'(1) << idx);
   assign frame_a  = word_base + 32'(idx) + base32;

   assign frame_f  = address_ff >> PG_SH;
   assign rel      = frame_f - base32;
   assign fword    = AW'(rel >> WSH);
   assign fbit     = rel[WSH-1:0];
   assign clr_word = rdata & ~(WORD_W'(1) << fbit);

   always_comb begin
      stat.clear_last = (ptr_ff == HW'(DEPTH - 1));
      stat.is_free    = (opcode_ff == pfba_pkg::OP_FREE);
      stat.in_range   = (frame_f >= base32) && (frame_f < base32 + n32);
      stat.past_end   = (word_base >= n32);
      stat.found      = |cand;
      stat.bit_used   = rdata[fbit];
      stat.slot_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      ram_we    = cmd.clear_wr || cmd.alloc_commit || cmd.free_commit;
      ram_re    = cmd.scan_rd || cmd.free_rd;
      ram_raddr = cmd.free_rd ? fword : ptr_ff[AW-1:0];
      ram_waddr = cmd.free_commit ? fword : ptr_ff[AW-1:0];
      priority if (cmd.alloc_commit) begin
         ram_wdata = set_word;
      end else if (cmd.free_commit) begin
         ram_wdata = clr_word;
      end else begin
         ram_wdata = '0;
      end
   end

   pfba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rdata)
   );

   always_comb begin
      ptr_in = ptr_ff;
      priority if (cmd.clear_wr || cmd.scan_inc) begin
         ptr_in = ptr_ff + HW'(1);
      end else if (cmd.scan_load) begin
         ptr_in = hint_ff;
      end else begin
         ptr_in = ptr_ff;
      end
      hint_in = hint_ff;
      priority if (cmd.alloc_commit) begin
         hint_in = (&set_word) ? ptr_ff + HW'(1) : ptr_ff;
      end else if (cmd.free_commit && (HW'(fword) < hint_ff)) begin
         hint_in = HW'(fword);
      end else begin
         hint_in = hint_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == pfba_pkg::CSR_BASE_FRAME) begin
            base_ff <= csr_data[pfba_pkg::BASE_W-1:0];
         end
         if (csr_we && csr_index == pfba_pkg::CSR_FRAME_COUNT) begin
            count_ff <= csr_data[pfba_pkg::COUNT_W-1:0];
         end
         ptr_ff  <= ptr_in;
         hint_ff <= hint_in;
         if (cmd.res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         opcode_ff  <= req_opcode;
         address_ff <= req_address;
      end
      if (cmd.res_load) begin
         status_ff    <= cmd.res_code;
         page_addr_ff <= cmd.alloc_commit ? (frame_a << PG_SH) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_address = page_addr_ff;
   assign rsp_status       = status_ff;

endmodule

`default_nettype wire

[hdl/pfba_ctrl.sv]
// Allocator controller: sequences map clearing, allocate scans and frees.
`default_nettype none

module pfba_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire pfba_pkg::stat_type stat,
   output pfba_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_ALLOC_RD,
      S_ALLOC_CHK,
      S_FREE_RD,
      S_FREE_CHK,
      S_REPLY
   } state_type;

   state_type            state_ff;
   logic                 ready_ff;
   pfba_pkg::status_type reply_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         ready_ff      <= 1'b0;
         reply_code_ff <= pfba_pkg::ST_OK;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               if (stat.clear_last) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DECODE;
                  ready_ff <= 1'b0;
               end
            end
            S_DECODE: begin
               priority if (!stat.is_free) begin
                  state_ff <= S_ALLOC_RD;
               end else if (stat.in_range) begin
                  state_ff <= S_FREE_RD;
               end else begin
                  reply_code_ff <= pfba_pkg::ST_RANGE;
                  state_ff      <= S_REPLY;
               end
            end
            S_ALLOC_RD: begin
               if (stat.past_end) begin
                  reply_code_ff <= pfba_pkg::ST_NO_FRAME;
                  state_ff      <= S_REPLY;
               end else begin
                  state_ff <= S_ALLOC_CHK;
               end
            end
            S_ALLOC_CHK: begin
               priority if (!stat.found) begin
                  state_ff <= S_ALLOC_RD;
               end else if (stat.slot_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end else begin
                  state_ff <= S_ALLOC_CHK;
               end
            end
            S_FREE_RD: begin
               state_ff <= S_FREE_CHK;
            end
            S_FREE_CHK, S_REPLY: begin
               if (stat.slot_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_CLEAR;
               ready_ff <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.res_code = pfba_pkg::ST_OK;
      unique case (state_ff)
         S_CLEAR:    cmd.clear_wr  = 1'b1;
         S_IDLE:     cmd.latch_req = req_valid && ready_ff;
         S_DECODE:   cmd.scan_load = !stat.is_free;
         S_ALLOC_RD: cmd.scan_rd   = !stat.past_end;
         S_ALLOC_CHK: begin
            if (stat.found) begin
               cmd.alloc_commit = stat.slot_free;
               cmd.res_load     = stat.slot_free;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         S_FREE_RD:  cmd.free_rd = 1'b1;
         S_FREE_CHK: begin
            cmd.res_load    = stat.slot_free;
            cmd.free_commit = stat.slot_free && stat.bit_used;
            cmd.res_code    = stat.bit_used ? pfba_pkg::ST_OK : pfba_pkg::ST_NOT_USED;
         end
         S_REPLY: begin
            cmd.res_load = stat.slot_free;
            cmd.res_code = reply_code_ff;
         end
         default: cmd = '0;
      endcase
   end

   assign req_ready = ready_ff;

endmodule

`default_nettype wire

[hdl/page_frame_bitmap_allocator.sv]
// Top level of the first-fit page frame bitmap allocator.
//
//   channel  dir  handshake       word
//   req_ch   in   valid/ready     opcode, address
//   rsp_ch   out  valid/ready     page_address, status
//   csr_ch   in   valid/ready     index, data (always ready)
//
// Free: S_FREE_RD reads the map word and S_FREE_CHK loads the result; a frame out of
// range loads its result in S_REPLY. Allocate: one 32-bit word is read per S_ALLOC_RD and
// S_ALLOC_CHK pair from the lowest word that may hold a free bit; no free frame ends in
// S_REPLY. req_ch is ready from the edge that loads a result. After reset the map is
// cleared one word a cycle, all ceil(MAX_FRAMES/32) words, with req_ch not ready. A
// result waiting on rsp_ch keeps the request in its last state, req_ch low, until taken.
`default_nettype none

module page_frame_bitmap_allocator #(
   parameter int MAX_FRAMES = pfba_pkg::DEF_MAX_FRAMES,
   parameter int PAGE_BYTES = pfba_pkg::DEF_PAGE_BYTES
) (
   input wire logic clock,
   input wire logic reset,
   pfba_req_if.sink   req_ch,
   pfba_rsp_if.source rsp_ch,
   pfba_csr_if.sink   csr_ch
);

   pfba_pkg::cmd_type  cmd;
   pfba_pkg::stat_type stat;

   assign csr_ch.ready = 1'b1;

   pfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfba_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_we           (csr_ch.valid),
      .csr_index        (csr_ch.index),
      .csr_data         (csr_ch.data),
      .req_opcode       (req_ch.opcode),
      .req_address      (req_ch.address),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_page_address (rsp_ch.page_address),
      .rsp_status       (rsp_ch.status)
   );

endmodule

`default_nettype wire
